>>> src/sdte_pkg.sv
package sdte_pkg;

    localparam logic [7:0] SOF_BYTE   = 8'hF0;
    localparam logic [7:0] EOX_BYTE   = 8'hF7;
    localparam logic [7:0] LCD_UNUSED = 8'hFF;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [8:0] MIN_BODY   = 9'd6;
    localparam logic [8:0] POS_MAX    = 9'd511;

    localparam logic [2:0] CFG_MANUF  = 3'd0;
    localparam logic [2:0] CFG_MTYPE  = 3'd1;
    localparam logic [2:0] CFG_LCD    = 3'd2;
    localparam logic [2:0] CFG_OFFSET = 3'd3;
    localparam logic [2:0] CFG_LENGTH = 3'd4;

    localparam logic KIND_CHUNK   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_CAP  = 11'b00000000010,
        S_LCHK = 11'b00000000100,
        S_TRD  = 11'b00000001000,
        S_TRC  = 11'b00000010000,
        S_CRD  = 11'b00000100000,
        S_CCK  = 11'b00001000000,
        S_CPR  = 11'b00010000000,
        S_CPW  = 11'b00100000000,
        S_EMIT = 11'b01000000000,
        S_SUM  = 11'b10000000000
    } t_state;

    typedef struct packed {
        logic       kind;
        logic [1:0] line_index;
        logic [4:0] chunk_start;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic [4:0] text_length;
        logic       matched;
        logic [3:0] changed_mask;
        logic       last;
    } t_result;

endpackage

>>> src/sdte_obuf.sv
module sdte_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sdte_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // line_index, chunk_start, char_first..char_fourth, text_length, matched,
    // changed_mask, zero fill
    output logic [55:0]       o_m_tdata,
    output logic              o_m_tuser,  // result_kind
    output logic              o_m_tlast
);
    import sdte_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_res.kind;
    assign o_m_tlast  = r_res.last;
    assign o_m_tdata  = {7'd0, r_res.changed_mask, r_res.matched, r_res.text_length,
                         r_res.c3, r_res.c2, r_res.c1, r_res.c0,
                         r_res.chunk_start, r_res.line_index};

endmodule

>>> src/sysex_display_text_extractor.sv
// SysEx display text extractor.
// Slave stream: one SysEx byte per transaction in tdata, tlast on the final
// byte. Master stream: result transactions; tuser is the kind (0 text chunk,
// 1 summary), tlast marks the summary that closes each message.
// Config channel: index 0..4 selects manufacturer id, message type, LCD
// table, offset table, length table; data is 32 bits. Always ready.
// Each byte is handled with one window write per line into the window
// memory. At the end of a message each matching line walks its characters
// one at a time, trimming trailing spaces, then comparing them with the
// stored text and copying them when they differ; the single read port of
// each text memory sets this pace.
// Throughput for back-to-back short messages is one summary per message.
// A stalled master holds the result register; the sequencer waits for it
// to free before loading the next chunk or summary, and no byte is taken
// until the summary is loaded.
// Synchronous reset clears control state, lengths and config to defaults;
// memories need no clearing.
module sysex_display_text_extractor #(
    parameter int LINES    = 4,
    parameter int TEXT_MAX = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // line_index, chunk_start, char_first..char_fourth, text_length, matched,
    // changed_mask, zero fill
    output logic [55:0] o_m_tdata,
    output logic        o_m_tuser,   // result_kind
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import sdte_pkg::*;

    localparam int DEPTH = LINES * TEXT_MAX;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]  r_manuf, r_mtype;
    logic [31:0] r_lcd_tab, r_off_tab, r_len_tab;

    t_state      r_state;
    logic [8:0]  r_pos, r_len_total;
    logic        r_first, r_id_ok, r_type_ok, r_drop, r_last;
    logic [7:0]  r_lcd, r_byte;
    logic [1:0]  r_line;
    logic [4:0]  r_k, r_len;
    logic [4:0]  r_slen [LINES];
    logic        r_matched;
    logic [3:0]  r_mask;
    logic [7:0]  r_ch [4];

    logic [7:0]  r_win [DEPTH];
    logic [7:0]  r_st  [DEPTH];
    logic [7:0]  r_win_q, r_st_q;

    logic        w_free, w_load, w_last_line;
    t_result     w_res;
    logic [7:0]  w_lcd, w_off, w_tlen;
    logic [8:0]  w_pos_rel, w_pos_next, w_rem, w_eff9, w_total;
    logic        w_cap_hit, w_skip;
    logic [AW-1:0] w_base, w_raddr, w_cap_addr;
    logic [4:0]  w_rk;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manuf   <= 8'h7D;
            r_mtype   <= 8'h01;
            r_lcd_tab <= 32'hFFFF_FFFF;
            r_off_tab <= 32'd0;
            r_len_tab <= 32'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MANUF:  r_manuf   <= i_cfg_data[7:0];
                CFG_MTYPE:  r_mtype   <= i_cfg_data[7:0];
                CFG_LCD:    r_lcd_tab <= i_cfg_data;
                CFG_OFFSET: r_off_tab <= i_cfg_data;
                CFG_LENGTH: r_len_tab <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_lcd  = 8'(r_lcd_tab >> {r_line, 3'b000});
        w_off  = 8'(r_off_tab >> {r_line, 3'b000});
        w_tlen = 8'(r_len_tab >> {r_line, 3'b000});
        w_base = AW'(r_line) * AW'(TEXT_MAX);
        w_last_line = (r_line == 2'(LINES - 1));

        w_pos_rel  = r_pos - {1'b0, w_off};
        w_cap_hit  = !r_drop && (r_pos >= {1'b0, w_off}) && (w_pos_rel < 9'(TEXT_MAX));
        w_cap_addr = w_base + AW'(w_pos_rel[4:0]);

        w_pos_next = r_drop ? r_pos : ((r_pos == POS_MAX) ? r_pos : r_pos + 9'd1);
        w_total    = w_pos_next;
        if (!r_drop && r_byte == EOX_BYTE && w_pos_next != 9'd0) begin
            w_total = w_pos_next - 9'd1;
        end

        w_rem  = r_len_total - {1'b0, w_off};
        w_eff9 = {1'b0, w_tlen};
        if (w_eff9 > w_rem) w_eff9 = w_rem;
        if (w_eff9 > 9'(TEXT_MAX)) w_eff9 = 9'(TEXT_MAX);
        w_skip = (w_lcd == LCD_UNUSED) || (w_lcd != r_lcd) ||
                 ({1'b0, w_off} >= r_len_total) || (w_eff9 == 9'd0);

        w_rk    = (r_state == S_TRD) ? r_len - 5'd1 : r_k;
        w_raddr = w_base + AW'(w_rk);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CAP && w_cap_hit) begin
            r_win[w_cap_addr] <= r_byte;
        end
        r_win_q <= r_win[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CPW) begin
            r_st[w_raddr] <= r_win_q;
        end
        r_st_q <= r_st[w_raddr];
    end

    always_comb begin
        w_load = 1'b0;
        w_res  = '0;
        if (r_state == S_EMIT) begin
            w_load            = 1'b1;
            w_res.kind        = KIND_CHUNK;
            w_res.line_index  = r_line;
            w_res.chunk_start = {r_k[4:2], 2'b00};
            w_res.c0          = r_ch[0];
            w_res.c1          = r_ch[1];
            w_res.c2          = r_ch[2];
            w_res.c3          = r_ch[3];
            w_res.text_length = r_len;
        end else if (r_state == S_SUM) begin
            w_load             = 1'b1;
            w_res.kind         = KIND_SUMMARY;
            w_res.matched      = r_matched;
            w_res.changed_mask = r_mask;
            w_res.last         = 1'b1;
        end
    end

    sdte_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_res      (w_res),
        .o_free     (w_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= 9'd0;
            r_first   <= 1'b1;
            r_id_ok   <= 1'b0;
            r_type_ok <= 1'b0;
            r_lcd     <= 8'd0;
            r_line    <= 2'd0;
            r_k       <= 5'd0;
            r_matched <= 1'b0;
            r_mask    <= 4'd0;
            for (int i = 0; i < LINES; i++) r_slen[i] <= 5'd0;
            for (int i = 0; i < 4; i++) r_ch[i] <= 8'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_byte  <= i_s_tdata;
                        r_last  <= i_s_tlast;
                        r_drop  <= r_first && (i_s_tdata == SOF_BYTE);
                        r_first <= 1'b0;
                        r_line  <= 2'd0;
                        r_state <= S_CAP;
                    end
                end
                S_CAP: begin
                    if (r_line == 2'd0 && !r_drop) begin
                        if (r_pos == 9'd0) r_id_ok <= (r_byte == r_manuf);
                        if (r_pos == 9'd1) r_type_ok <= (r_byte == r_mtype);
                        if (r_pos == 9'd3) r_lcd <= r_byte;
                    end
                    if (w_last_line) begin
                        r_pos       <= w_pos_next;
                        r_len_total <= w_total;
                        r_line      <= 2'd0;
                        r_matched   <= 1'b0;
                        r_mask      <= 4'd0;
                        if (!r_last) begin
                            r_state <= S_IDLE;
                        end else if (w_total >= MIN_BODY && r_id_ok && r_type_ok) begin
                            r_state <= S_LCHK;
                        end else begin
                            r_state <= S_SUM;
                        end
                    end else begin
                        r_line <= r_line + 2'd1;
                    end
                end
                S_LCHK: begin
                    if (w_skip) begin
                        r_line  <= w_last_line ? r_line : r_line + 2'd1;
                        r_state <= w_last_line ? S_SUM : S_LCHK;
                    end else begin
                        r_len   <= w_eff9[4:0];
                        r_state <= S_TRD;
                    end
                end
                S_TRD: r_state <= S_TRC;
                S_TRC: begin
                    r_k <= 5'd0;
                    if (r_win_q == SPACE_CHAR) begin
                        if (r_len == 5'd1) begin
                            r_line  <= w_last_line ? r_line : r_line + 2'd1;
                            r_state <= w_last_line ? S_SUM : S_LCHK;
                        end else begin
                            r_len   <= r_len - 5'd1;
                            r_state <= S_TRD;
                        end
                    end else begin
                        r_matched <= 1'b1;
                        for (int i = 0; i < 4; i++) r_ch[i] <= 8'd0;
                        r_state <= (r_len == r_slen[r_line]) ? S_CRD : S_CPR;
                    end
                end
                S_CRD: r_state <= S_CCK;
                S_CCK: begin
                    if (r_win_q != r_st_q) begin
                        r_k     <= 5'd0;
                        r_state <= S_CPR;
                    end else if (r_k == r_len - 5'd1) begin
                        r_line  <= w_last_line ? r_line : r_line + 2'd1;
                        r_state <= w_last_line ? S_SUM : S_LCHK;
                    end else begin
                        r_k     <= r_k + 5'd1;
                        r_state <= S_CRD;
                    end
                end
                S_CPR: r_state <= S_CPW;
                S_CPW: begin
                    r_ch[r_k[1:0]] <= r_win_q;
                    if (r_k[1:0] == 2'd3 || r_k == r_len - 5'd1) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_k     <= r_k + 5'd1;
                        r_state <= S_CPR;
                    end
                end
                S_EMIT: begin
                    if (w_free) begin
                        for (int i = 0; i < 4; i++) r_ch[i] <= 8'd0;
                        if (r_k == r_len - 5'd1) begin
                            r_slen[r_line] <= r_len;
                            r_mask  <= r_mask | (4'd1 << r_line);
                            r_line  <= w_last_line ? r_line : r_line + 2'd1;
                            r_state <= w_last_line ? S_SUM : S_LCHK;
                        end else begin
                            r_k     <= r_k + 5'd1;
                            r_state <= S_CPR;
                        end
                    end
                end
                S_SUM: begin
                    if (w_free) begin
                        r_pos     <= 9'd0;
                        r_first   <= 1'b1;
                        r_id_ok   <= 1'b0;
                        r_type_ok <= 1'b0;
                        r_lcd     <= 8'd0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_sum_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && w_free) |=> (r_state == S_IDLE && r_first && r_pos == 9'd0))
        else $error("summary did not close the message");
    a_copy_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CPW || r_state == S_CCK) |-> (r_k < r_len))
        else $error("character index beyond text length");
    a_trim_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRD) |-> (r_len != 5'd0))
        else $error("trim on empty window");
    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !w_free) |=> (r_state == S_EMIT && $stable(r_k)))
        else $error("chunk lost under stall");
`endif

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import sdte_pkg::*;

    localparam int LINES      = 4;
    localparam int TEXT_MAX   = 31;
    localparam int CYCLE_MAX  = 1000000;
    localparam int ITEMS_GOAL = 480;
    localparam int QUIET_CYC  = 40;

    typedef enum logic { ROW_BYTE, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [7:0]  data;
        logic        last;
        logic [2:0]  idx;
        logic [31:0] val;
        bit          typed;
        logic        t_matched;
        logic [3:0]  t_mask;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [55:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    sysex_display_text_extractor #(.LINES(LINES), .TEXT_MAX(TEXT_MAX)) dut (.*);

    logic [7:0]  reg_manuf;
    logic [7:0]  reg_mtype;
    logic [31:0] reg_lcd;
    logic [31:0] reg_off;
    logic [31:0] reg_len;

    int          body_pos;
    bit          at_msg_start;
    bit          id_ok;
    bit          type_ok;
    logic [7:0]  lcd_seen;
    logic [7:0]  win_buf  [LINES][TEXT_MAX];
    logic [7:0]  line_text[LINES][TEXT_MAX];
    int          line_len [LINES];

    t_result     exp_results[$];
    t_stim_row   dir_rows[$];
    logic [7:0]  prev_msg[$];
    int          mismatches;
    int          failures;
    int          cycles;
    int          items_sent;
    bit          no_idle;
    int          hold_req;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] tab_byte(logic [31:0] t, int l);
        return t[8*l +: 8];
    endfunction

    task automatic predict_byte(logic [7:0] b, logic last, bit typed, logic t_m,
                                logic [3:0] t_mask);
        bit         dropped;
        int         total;
        int         n;
        int         start;
        logic [3:0] mask;
        bit         hit;
        bit         same;
        t_result    r;
        dropped = 1'b0;
        mask = '0;
        hit = 1'b0;
        if (at_msg_start && b == SOF_BYTE) begin
            dropped = 1'b1;
        end else begin
            if (body_pos == 0) id_ok = (b == reg_manuf);
            if (body_pos == 1) type_ok = (b == reg_mtype);
            if (body_pos == 3) lcd_seen = b;
            for (int l = 0; l < LINES; l++) begin
                start = int'(tab_byte(reg_off, l));
                if (body_pos >= start && body_pos - start < TEXT_MAX)
                    win_buf[l][body_pos - start] = b;
            end
            if (body_pos < 511) body_pos++;
        end
        at_msg_start = 1'b0;
        if (!last) return;
        total = body_pos;
        if (!dropped && b == EOX_BYTE && total > 0) total--;
        if (total >= 6 && id_ok && type_ok) begin
            for (int l = 0; l < LINES; l++) begin
                start = int'(tab_byte(reg_off, l));
                n = int'(tab_byte(reg_len, l));
                if (tab_byte(reg_lcd, l) == LCD_UNUSED || tab_byte(reg_lcd, l) != lcd_seen)
                    continue;
                if (start >= total) continue;
                if (start + n > total) n = total - start;
                if (n > TEXT_MAX) n = TEXT_MAX;
                while (n > 0 && win_buf[l][n-1] == SPACE_CHAR) n--;
                if (n == 0) continue;
                hit = 1'b1;
                same = (n == line_len[l]);
                for (int k = 0; k < n; k++)
                    if (win_buf[l][k] != line_text[l][k]) same = 1'b0;
                if (same) continue;
                for (int k = 0; k < TEXT_MAX; k++)
                    line_text[l][k] = (k < n) ? win_buf[l][k] : 8'h00;
                line_len[l] = n;
                mask[l] = 1'b1;
                for (int c = 0; c < n; c += 4) begin
                    r = '0;
                    r.kind = KIND_CHUNK;
                    r.line_index = 2'(l);
                    r.chunk_start = 5'(c);
                    r.c0 = line_text[l][c];
                    r.c1 = (c + 1 < n) ? line_text[l][c+1] : 8'h00;
                    r.c2 = (c + 2 < n) ? line_text[l][c+2] : 8'h00;
                    r.c3 = (c + 3 < n) ? line_text[l][c+3] : 8'h00;
                    r.text_length = 5'(n);
                    exp_results.push_back(r);
                end
            end
        end
        r = '0;
        r.kind = KIND_SUMMARY;
        r.matched = typed ? t_m : hit;
        r.changed_mask = typed ? t_mask : mask;
        r.last = 1'b1;
        exp_results.push_back(r);
        body_pos = 0;
        at_msg_start = 1'b1;
        id_ok = 1'b0;
        type_ok = 1'b0;
        lcd_seen = '0;
    endtask

    task automatic idle_gap();
        int g;
        if (no_idle) return;
        g = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 30);
        if (g > 0) begin
            i_s_tvalid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic send_byte(logic [7:0] b, logic last, bit typed, logic t_m,
                             logic [3:0] t_mask);
        idle_gap();
        i_s_tvalid = 1'b1;
        i_s_tdata = b;
        i_s_tlast = last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_byte(b, last, typed, t_m, t_mask);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_s_tvalid = 1'b0;
        while (exp_results.size() > 0) @(negedge i_clk);
        repeat (QUIET_CYC) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_MANUF:  reg_manuf = val[7:0];
            CFG_MTYPE:  reg_mtype = val[7:0];
            CFG_LCD:    reg_lcd = val;
            CFG_OFFSET: reg_off = val;
            CFG_LENGTH: reg_len = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic add_byte(logic [7:0] b, logic last, bit typed = 1'b0, logic t_m = 1'b0,
                            logic [3:0] t_mask = '0);
        t_stim_row r;
        r = '{ROW_BYTE, b, last, '0, '0, typed, t_m, t_mask};
        dir_rows.push_back(r);
    endtask

    task automatic add_cfg(logic [2:0] idx, logic [31:0] val);
        t_stim_row r;
        r = '{ROW_CFG, '0, 1'b0, idx, val, 1'b0, 1'b0, '0};
        dir_rows.push_back(r);
    endtask

    function automatic logic [7:0] rand_char();
        int p;
        p = $urandom_range(0, 9);
        if (p < 2) return SPACE_CHAR;
        if (p < 8) return 8'(32'h41 + $urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic rand_config(int ph);
        logic [31:0] lcd, off, len;
        for (int l = 0; l < LINES; l++) begin
            lcd[8*l +: 8] = ($urandom_range(0, 4) == 0) ? LCD_UNUSED :
                            8'($urandom_range(0, 5));
            off[8*l +: 8] = ($urandom_range(0, 15) == 0) ? 8'hFF : 8'($urandom_range(0, 20));
            len[8*l +: 8] = ($urandom_range(0, 15) == 0) ? 8'hFF : 8'($urandom_range(0, 31));
        end
        case (ph)
            0: begin
                cfg_write(CFG_MANUF, 32'hFFFF_FFFF);
                cfg_write(CFG_MTYPE, 32'h0);
            end
            1: begin
                cfg_write(CFG_MANUF, 32'h0);
                cfg_write(CFG_MTYPE, 32'hFF);
                cfg_write(3'd7, $urandom());
            end
            default: begin
                cfg_write(CFG_MANUF, $urandom());
                cfg_write(CFG_MTYPE, $urandom());
            end
        endcase
        cfg_write(CFG_LCD, lcd);
        cfg_write(CFG_OFFSET, off);
        cfg_write(CFG_LENGTH, len);
    endtask

    task automatic rand_message(bit long_msg);
        logic [7:0] msg[$];
        int n;
        if (!long_msg && prev_msg.size() > 0 && $urandom_range(0, 3) == 0) begin
            msg = prev_msg;
        end else if (!long_msg && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) msg.push_back(8'($urandom()));
        end else begin
            if ($urandom_range(0, 3) != 0) msg.push_back(SOF_BYTE);
            msg.push_back(($urandom_range(0, 9) != 0) ? reg_manuf : 8'($urandom()));
            msg.push_back(($urandom_range(0, 9) != 0) ? reg_mtype : 8'($urandom()));
            msg.push_back(8'($urandom()));
            msg.push_back(($urandom_range(0, 6) != 0) ?
                          tab_byte(reg_lcd, $urandom_range(0, LINES - 1)) : 8'($urandom()));
            if (long_msg) n = 120;
            else if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 2);
            else if ($urandom_range(0, 7) == 0) n = $urandom_range(25, 40);
            else n = $urandom_range(3, 16);
            repeat (n) msg.push_back(rand_char());
            if ($urandom_range(0, 9) < 7) msg.push_back(EOX_BYTE);
        end
        prev_msg = msg;
        foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1, 1'b0, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        t_result act;
        t_result exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            act.kind = o_m_tuser;
            act.line_index = o_m_tdata[1:0];
            act.chunk_start = o_m_tdata[6:2];
            act.c0 = o_m_tdata[14:7];
            act.c1 = o_m_tdata[22:15];
            act.c2 = o_m_tdata[30:23];
            act.c3 = o_m_tdata[38:31];
            act.text_length = o_m_tdata[43:39];
            act.matched = o_m_tdata[44];
            act.changed_mask = o_m_tdata[48:45];
            act.last = o_m_tlast;
            if (exp_results.size() == 0) begin
                failures++;
                if (mismatches++ < 10) $display("unexpected result %h", act);
            end else begin
                exp_r = exp_results.pop_front();
                if (act !== exp_r) begin
                    failures++;
                    if (mismatches++ < 10)
                        $display("mismatch: expected %h actual %h", exp_r, act);
                end
            end
        end
    end

    initial begin
        int seen_req;
        int hold;
        seen_req = 0;
        hold = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != seen_req) begin
                seen_req = hold_req;
                hold = 400;
            end
            if (hold > 0) begin
                i_m_tready = 1'b0;
                hold--;
            end else if (no_idle) begin
                i_m_tready = 1'b1;
            end else if ($urandom_range(0, 29) == 0) begin
                i_m_tready = 1'b0;
                hold = $urandom_range(5, 40);
            end else begin
                i_m_tready = ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        t_stim_row row;
        int ph;
        cycles = 0;
        mismatches = 0;
        failures = 0;
        items_sent = 0;
        no_idle = 1'b0;
        hold_req = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tlast = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        reg_manuf = 8'h7D;
        reg_mtype = 8'h01;
        reg_lcd = 32'hFFFF_FFFF;
        reg_off = '0;
        reg_len = '0;
        body_pos = 0;
        at_msg_start = 1'b1;
        id_ok = 1'b0;
        type_ok = 1'b0;
        lcd_seen = '0;
        for (int l = 0; l < LINES; l++) begin
            line_len[l] = 0;
            for (int k = 0; k < TEXT_MAX; k++) begin
                win_buf[l][k] = '0;
                line_text[l][k] = '0;
            end
        end
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        add_byte(8'h00, 1'b1, 1, 0, 4'h0);
        add_byte(SOF_BYTE, 1'b1, 1, 0, 4'h0);
        add_byte(EOX_BYTE, 1'b1, 1, 0, 4'h0);
        add_cfg(CFG_LCD, 32'hFFFF_0505);
        add_cfg(CFG_OFFSET, 32'h0000_0204);
        add_cfg(CFG_LENGTH, 32'h0000_041F);
        for (int rep = 0; rep < 2; rep++) begin
            if (rep == 0) add_byte(SOF_BYTE, 1'b0);
            add_byte(8'h7D, 1'b0);
            add_byte(8'h01, 1'b0);
            add_byte(8'h00, 1'b0);
            add_byte(8'h05, 1'b0);
            add_byte(8'h41, 1'b0);
            add_byte(8'h42, 1'b0);
            add_byte(SPACE_CHAR, 1'b0);
            add_byte(8'hFF, 1'b0);
            if (rep == 0) add_byte(EOX_BYTE, 1'b1);
            else add_byte(EOX_BYTE, 1'b1, 1, 1, 4'h0);
        end
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                wait_drain();
                cfg_write(row.idx, row.val);
            end else begin
                send_byte(row.data, row.last, row.typed, row.t_matched, row.t_mask);
            end
        end

        ph = 0;
        while (items_sent < ITEMS_GOAL + dir_rows.size()) begin
            wait_drain();
            rand_config(ph);
            no_idle = (ph == 1);
            if (ph == 0) hold_req++;
            if (ph == 2) rand_message(1);
            repeat (8) rand_message(0);
            ph++;
        end
        wait_drain();
        repeat (QUIET_CYC) @(posedge i_clk);
        if (failures == 0 && exp_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
